/* hw/rtl/tsbn_pkg.sv */
// ----------------------------------------------------------------------------
// tsbn_pkg
// Types and constants shared by the triangle box and normal block.
// ----------------------------------------------------------------------------
`default_nettype none

package tsbn_pkg;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TSTEP = 8'd1;

  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  typedef enum logic [15:0] {
    S_IDLE      = 16'h0001,
    S_BOX       = 16'h0002,
    S_ADV_MUL   = 16'h0004,
    S_ADV_ACC   = 16'h0008,
    S_CR_MUL    = 16'h0010,
    S_CR_ACC    = 16'h0020,
    S_ABS       = 16'h0040,
    S_NORM      = 16'h0080,
    S_SQ_MUL    = 16'h0100,
    S_SQ_ACC    = 16'h0200,
    S_SQRT_INIT = 16'h0400,
    S_SQRT      = 16'h0800,
    S_DIV_INIT  = 16'h1000,
    S_DIV       = 16'h2000,
    S_DIV_FIN   = 16'h4000,
    S_EMIT      = 16'h8000
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_BOX,
    OP_ADV_MUL,
    OP_ADV_ACC,
    OP_CR_MUL,
    OP_CR_ACC,
    OP_ABS,
    OP_NORM,
    OP_SQ_MUL,
    OP_SQ_ACC,
    OP_SQRT_INIT,
    OP_SQRT,
    OP_DIV_INIT,
    OP_DIV,
    OP_DIV_FIN,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [3:0]  sel;
    logic [15:0] tri_idx;
  } cmd_t;

  typedef struct packed {
    logic sweep;
    logic zero;
    logic norm_done;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } corner_t;

  typedef struct packed {
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic               degenerate;
    logic [15:0]        triangle_index;
  } result_t;

  // Edge-1 axis of the cross product term chosen by the term number
  function automatic logic [1:0] cross_a(input logic [2:0] term);
    logic [1:0] a;
    unique case (term)
      3'd0:    a = 2'd1;
      3'd1:    a = 2'd2;
      3'd2:    a = 2'd2;
      3'd3:    a = 2'd0;
      3'd4:    a = 2'd0;
      3'd5:    a = 2'd1;
      default: a = 2'd0;
    endcase
    return a;
  endfunction

  // Edge-2 axis of the same term
  function automatic logic [1:0] cross_b(input logic [2:0] term);
    logic [1:0] b;
    unique case (term)
      3'd0:    b = 2'd2;
      3'd1:    b = 2'd1;
      3'd2:    b = 2'd0;
      3'd3:    b = 2'd2;
      3'd4:    b = 2'd1;
      3'd5:    b = 2'd0;
      default: b = 2'd0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/tsbn_if.sv */
// ----------------------------------------------------------------------------
// tsbn_if
// Channel interfaces: corner input, result output and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsbn_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

interface tsbn_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] box_min_x;
  logic signed [31:0] box_min_y;
  logic signed [31:0] box_min_z;
  logic signed [31:0] box_max_x;
  logic signed [31:0] box_max_y;
  logic signed [31:0] box_max_z;
  logic signed [31:0] normal_x;
  logic signed [31:0] normal_y;
  logic signed [31:0] normal_z;
  logic               degenerate;
  logic [15:0]        triangle_index;
  modport source (output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                  box_max_z, normal_x, normal_y, normal_z, degenerate, triangle_index,
                  input ready);
  modport sink (input valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                box_max_z, normal_x, normal_y, normal_z, degenerate, triangle_index,
                output ready);
endinterface

interface tsbn_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/tsbn_datapath.sv */
// ----------------------------------------------------------------------------
// tsbn_datapath
// Corner store, box bounds, shared multiplier, normalizer, square root and
// divider, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tsbn_datapath (
  input  wire                 clk,
  input  wire                 rst_n,
  input  tsbn_pkg::cmd_t      cmd,
  output tsbn_pkg::sts_t      sts,
  input  tsbn_pkg::corner_t   in_corner,
  input  wire                 cfg_we,
  input  wire [7:0]           cfg_index,
  input  wire [31:0]          cfg_data,
  output tsbn_pkg::result_t   out_data,
  output logic                out_valid,
  input  wire                 out_ready
);

  logic signed [31:0] pos_r [3][3];
  logic signed [31:0] vel_r [3][3];
  logic signed [31:0] lo_r [3];
  logic signed [31:0] hi_r [3];
  logic signed [32:0] e1_r [3];
  logic signed [32:0] e2_r [3];
  logic signed [65:0] prod_r;
  logic [66:0]        cr_r [3];
  logic [2:0]         neg_r;
  logic [63:0]        s_r;
  logic [63:0]        v_r;
  logic [63:0]        rt_r;
  logic [63:0]        bit_r;
  logic [63:0]        pr_r;
  logic signed [31:0] nrm_r [3];
  logic               deg_r;
  logic               sweep_r;
  logic [31:0]        tstep_r;
  tsbn_pkg::result_t  out_r;
  logic               out_valid_r;

  logic [1:0]  k_sel;
  logic [1:0]  i_sel;
  logic [2:0]  term;
  logic [1:0]  ax_a;
  logic [1:0]  ax_b;
  logic [66:0] or_all;
  logic [5:0]  rshift;
  logic [4:0]  lshift;
  logic signed [49:0] adv_d;
  logic signed [50:0] adv_sum;
  logic signed [31:0] adv_sat;
  logic [63:0] sq_t;
  logic [32:0] div_t;
  logic [32:0] div_diff;
  logic        div_ge;
  logic [31:0] q_clip;
  logic [63:0] num;

  assign k_sel = cmd.sel[3:2];
  assign i_sel = cmd.sel[1:0];
  assign term  = cmd.sel[2:0];
  assign ax_a  = tsbn_pkg::cross_a(term);
  assign ax_b  = tsbn_pkg::cross_b(term);

  assign or_all = cr_r[0] | cr_r[1] | cr_r[2];

  always_comb begin
    priority if (|or_all[66:62]) rshift = 6'd32;
    else if (|or_all[66:46])     rshift = 6'd16;
    else if (|or_all[66:38])     rshift = 6'd8;
    else if (|or_all[66:34])     rshift = 6'd4;
    else if (|or_all[66:32])     rshift = 6'd2;
    else                         rshift = 6'd1;
    priority if (~|or_all[66:15]) lshift = 5'd16;
    else if (~|or_all[66:23])     lshift = 5'd8;
    else if (~|or_all[66:27])     lshift = 5'd4;
    else if (~|or_all[66:29])     lshift = 5'd2;
    else                          lshift = 5'd1;
  end

  // Advanced corner: floor of the product to Q16.16, add, saturate
  assign adv_d   = prod_r[65:16];
  assign adv_sum = 51'(pos_r[k_sel][i_sel]) + 51'(adv_d);
  always_comb begin
    priority if (adv_sum > 51'sd2147483647)       adv_sat = 32'sh7FFF_FFFF;
    else if (adv_sum < -51'sd2147483648)          adv_sat = 32'sh8000_0000;
    else                                          adv_sat = adv_sum[31:0];
  end

  assign sq_t     = rt_r + bit_r;
  assign div_t    = pr_r[63:31];
  assign div_diff = div_t - {1'b0, rt_r[31:0]};
  assign div_ge   = div_t >= {1'b0, rt_r[31:0]};
  assign q_clip   = (pr_r[31:0] > tsbn_pkg::ONE_Q30) ? tsbn_pkg::ONE_Q30 : pr_r[31:0];
  assign num      = {3'b0, cr_r[term[1:0]][30:0], 30'b0} + {1'b0, rt_r[63:1]};

  function automatic logic signed [31:0] min3(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               input logic signed [31:0] c);
    logic signed [31:0] m;
    m = (a < b) ? a : b;
    return (c < m) ? c : m;
  endfunction

  function automatic logic signed [31:0] max3(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               input logic signed [31:0] c);
    logic signed [31:0] m;
    m = (a > b) ? a : b;
    return (c > m) ? c : m;
  endfunction

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      tsbn_pkg::OP_CAPTURE: begin
        pos_r[k_sel[1:0] == 2'd0 ? i_sel : i_sel][0] <= in_corner.pos_x;
        pos_r[i_sel][1] <= in_corner.pos_y;
        pos_r[i_sel][2] <= in_corner.pos_z;
        vel_r[i_sel][0] <= in_corner.vel_x;
        vel_r[i_sel][1] <= in_corner.vel_y;
        vel_r[i_sel][2] <= in_corner.vel_z;
      end
      tsbn_pkg::OP_BOX: begin
        for (int i = 0; i < 3; i++) begin
          lo_r[i] <= min3(pos_r[0][i], pos_r[1][i], pos_r[2][i]);
          hi_r[i] <= max3(pos_r[0][i], pos_r[1][i], pos_r[2][i]);
          e1_r[i] <= 33'(pos_r[1][i]) - 33'(pos_r[0][i]);
          e2_r[i] <= 33'(pos_r[2][i]) - 33'(pos_r[0][i]);
        end
      end
      tsbn_pkg::OP_ADV_MUL: begin
        prod_r <= 66'(vel_r[k_sel][i_sel] * $signed({1'b0, tstep_r}));
      end
      tsbn_pkg::OP_ADV_ACC: begin
        if (adv_sat < lo_r[i_sel]) lo_r[i_sel] <= adv_sat;
        if (adv_sat > hi_r[i_sel]) hi_r[i_sel] <= adv_sat;
      end
      tsbn_pkg::OP_CR_MUL: begin
        prod_r <= e1_r[ax_a] * e2_r[ax_b];
      end
      tsbn_pkg::OP_CR_ACC: begin
        if (!term[0]) cr_r[term[2:1]] <= 67'(prod_r);
        else          cr_r[term[2:1]] <= cr_r[term[2:1]] - 67'(prod_r);
      end
      tsbn_pkg::OP_ABS: begin
        for (int j = 0; j < 3; j++) begin
          neg_r[j] <= cr_r[j][66];
          cr_r[j]  <= cr_r[j][66] ? (67'd0 - cr_r[j]) : cr_r[j];
          nrm_r[j] <= '0;
        end
        deg_r <= ~|(cr_r[0] | cr_r[1] | cr_r[2]);
        s_r   <= '0;
      end
      tsbn_pkg::OP_NORM: begin
        for (int j = 0; j < 3; j++) begin
          if (|or_all[66:31]) cr_r[j] <= cr_r[j] >> rshift;
          else                cr_r[j] <= cr_r[j] << lshift;
        end
      end
      tsbn_pkg::OP_SQ_MUL: begin
        prod_r <= 66'($signed({1'b0, cr_r[term[1:0]][30:0]}) *
                      $signed({1'b0, cr_r[term[1:0]][30:0]}));
      end
      tsbn_pkg::OP_SQ_ACC: begin
        s_r <= s_r + prod_r[63:0];
      end
      tsbn_pkg::OP_SQRT_INIT: begin
        v_r   <= s_r;
        rt_r  <= '0;
        bit_r <= 64'd1 << 62;
      end
      tsbn_pkg::OP_SQRT: begin
        if (v_r >= sq_t) begin
          v_r  <= v_r - sq_t;
          rt_r <= (rt_r >> 1) + bit_r;
        end else begin
          rt_r <= rt_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      tsbn_pkg::OP_DIV_INIT: begin
        pr_r <= num;
      end
      tsbn_pkg::OP_DIV: begin
        pr_r <= {div_ge ? div_diff[31:0] : div_t[31:0], pr_r[30:0], div_ge};
      end
      tsbn_pkg::OP_DIV_FIN: begin
        nrm_r[term[1:0]] <= neg_r[term[1:0]] ? -$signed(q_clip) : $signed(q_clip);
      end
      tsbn_pkg::OP_EMIT: begin
        out_r.box_min_x      <= lo_r[0];
        out_r.box_min_y      <= lo_r[1];
        out_r.box_min_z      <= lo_r[2];
        out_r.box_max_x      <= hi_r[0];
        out_r.box_max_y      <= hi_r[1];
        out_r.box_max_z      <= hi_r[2];
        out_r.normal_x       <= nrm_r[0];
        out_r.normal_y       <= nrm_r[1];
        out_r.normal_z       <= nrm_r[2];
        out_r.degenerate     <= deg_r;
        out_r.triangle_index <= cmd.tri_idx;
      end
      tsbn_pkg::OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sweep_r     <= 1'b0;
      tstep_r     <= '0;
    end else begin
      if (cmd.op == tsbn_pkg::OP_EMIT) out_valid_r <= 1'b1;
      else if (out_ready)              out_valid_r <= 1'b0;
      if (cfg_we && cfg_index == tsbn_pkg::REG_SWEEP) sweep_r <= cfg_data[0];
      if (cfg_we && cfg_index == tsbn_pkg::REG_TSTEP) tstep_r <= cfg_data;
    end
  end

  assign sts.sweep     = sweep_r;
  assign sts.zero      = ~|or_all;
  assign sts.norm_done = ~|or_all[66:31] && or_all[30];
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* hw/rtl/tsbn_ctrl.sv */
// ----------------------------------------------------------------------------
// tsbn_ctrl
// Sequencer: corner counting, triangle numbering and the per-triangle steps.
// ----------------------------------------------------------------------------
`default_nettype none

module tsbn_ctrl #(
  parameter int unsigned MAX_TRIANGLES = 65536
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  tsbn_pkg::sts_t      sts,
  output tsbn_pkg::cmd_t      cmd
);

  tsbn_pkg::state_t state_r, state_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [4:0]  it_r, it_nxt;
  logic [1:0]  corner_r, corner_nxt;
  logic [15:0] tri_r, tri_nxt;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    it_nxt      = it_r;
    corner_nxt  = corner_r;
    tri_nxt     = tri_r;
    in_ready    = 1'b0;
    cmd.op      = tsbn_pkg::OP_NONE;
    cmd.sel     = cnt_r;
    cmd.tri_idx = tri_r;
    unique case (state_r)
      tsbn_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op  = tsbn_pkg::OP_CAPTURE;
          cmd.sel = {2'b00, corner_r};
          if (corner_r == 2'd2) begin
            corner_nxt = 2'd0;
            state_nxt  = tsbn_pkg::S_BOX;
          end else begin
            corner_nxt = corner_r + 2'd1;
          end
        end
      end
      tsbn_pkg::S_BOX: begin
        cmd.op  = tsbn_pkg::OP_BOX;
        cnt_nxt = '0;
        state_nxt = sts.sweep ? tsbn_pkg::S_ADV_MUL : tsbn_pkg::S_CR_MUL;
      end
      tsbn_pkg::S_ADV_MUL: begin
        cmd.op    = tsbn_pkg::OP_ADV_MUL;
        state_nxt = tsbn_pkg::S_ADV_ACC;
      end
      tsbn_pkg::S_ADV_ACC: begin
        // walk axis then corner
        cmd.op = tsbn_pkg::OP_ADV_ACC;
        if (cnt_r == {2'd2, 2'd2}) begin
          cnt_nxt   = '0;
          state_nxt = tsbn_pkg::S_CR_MUL;
        end else begin
          cnt_nxt   = (cnt_r[1:0] == 2'd2) ? {cnt_r[3:2] + 2'd1, 2'd0} : cnt_r + 4'd1;
          state_nxt = tsbn_pkg::S_ADV_MUL;
        end
      end
      tsbn_pkg::S_CR_MUL: begin
        cmd.op    = tsbn_pkg::OP_CR_MUL;
        state_nxt = tsbn_pkg::S_CR_ACC;
      end
      tsbn_pkg::S_CR_ACC: begin
        cmd.op = tsbn_pkg::OP_CR_ACC;
        if (cnt_r == 4'd5) begin
          cnt_nxt   = '0;
          state_nxt = tsbn_pkg::S_ABS;
        end else begin
          cnt_nxt   = cnt_r + 4'd1;
          state_nxt = tsbn_pkg::S_CR_MUL;
        end
      end
      tsbn_pkg::S_ABS: begin
        cmd.op    = tsbn_pkg::OP_ABS;
        state_nxt = tsbn_pkg::S_NORM;
      end
      tsbn_pkg::S_NORM: begin
        priority if (sts.zero) begin
          state_nxt = tsbn_pkg::S_EMIT;
        end else if (sts.norm_done) begin
          cnt_nxt   = '0;
          state_nxt = tsbn_pkg::S_SQ_MUL;
        end else begin
          cmd.op = tsbn_pkg::OP_NORM;
        end
      end
      tsbn_pkg::S_SQ_MUL: begin
        cmd.op    = tsbn_pkg::OP_SQ_MUL;
        state_nxt = tsbn_pkg::S_SQ_ACC;
      end
      tsbn_pkg::S_SQ_ACC: begin
        cmd.op = tsbn_pkg::OP_SQ_ACC;
        if (cnt_r == 4'd2) begin
          cnt_nxt   = '0;
          state_nxt = tsbn_pkg::S_SQRT_INIT;
        end else begin
          cnt_nxt   = cnt_r + 4'd1;
          state_nxt = tsbn_pkg::S_SQ_MUL;
        end
      end
      tsbn_pkg::S_SQRT_INIT: begin
        cmd.op    = tsbn_pkg::OP_SQRT_INIT;
        it_nxt    = '0;
        state_nxt = tsbn_pkg::S_SQRT;
      end
      tsbn_pkg::S_SQRT: begin
        cmd.op = tsbn_pkg::OP_SQRT;
        it_nxt = it_r + 5'd1;
        if (it_r == 5'd31) begin
          cnt_nxt   = '0;
          state_nxt = tsbn_pkg::S_DIV_INIT;
        end
      end
      tsbn_pkg::S_DIV_INIT: begin
        cmd.op    = tsbn_pkg::OP_DIV_INIT;
        it_nxt    = '0;
        state_nxt = tsbn_pkg::S_DIV;
      end
      tsbn_pkg::S_DIV: begin
        cmd.op = tsbn_pkg::OP_DIV;
        it_nxt = it_r + 5'd1;
        if (it_r == 5'd31) state_nxt = tsbn_pkg::S_DIV_FIN;
      end
      tsbn_pkg::S_DIV_FIN: begin
        cmd.op = tsbn_pkg::OP_DIV_FIN;
        if (cnt_r == 4'd2) begin
          state_nxt = tsbn_pkg::S_EMIT;
        end else begin
          cnt_nxt   = cnt_r + 4'd1;
          state_nxt = tsbn_pkg::S_DIV_INIT;
        end
      end
      tsbn_pkg::S_EMIT: begin
        // hold until the result register frees up
        if (sts.out_free) begin
          cmd.op    = tsbn_pkg::OP_EMIT;
          tri_nxt   = (17'(tri_r) == 17'(MAX_TRIANGLES - 1)) ? 16'd0 : tri_r + 16'd1;
          state_nxt = tsbn_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tsbn_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tsbn_pkg::S_IDLE;
      cnt_r    <= '0;
      it_r     <= '0;
      corner_r <= '0;
      tri_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      it_r     <= it_nxt;
      corner_r <= corner_nxt;
      tri_r    <= tri_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/triangle_swept_box_and_normal_core.sv */
// The block takes corners only while idle. After the third corner it takes
// none until the triangle's result is emitted, after any wait for the result
// register (more steps with sweep on; a zero cross product skips the root and
// divider): a shared multiplier, a 32-step square root and a divider run per
// normal component. Reset (rst_n low, synchronous) clears corner count,
// triangle number, configuration registers and the result valid.
// ----------------------------------------------------------------------------
// triangle_swept_box_and_normal_core
// Triangle bounding box (optionally swept) and unit face normal.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_swept_box_and_normal_core #(
  parameter int unsigned MAX_TRIANGLES = 65536
) (
  input  wire         clk,
  input  wire         rst_n,
  tsbn_in_if.sink     in_ch,
  tsbn_out_if.source  out_ch,
  tsbn_cfg_if.sink    cfg_ch
);

  tsbn_pkg::cmd_t    cmd;
  tsbn_pkg::sts_t    sts;
  tsbn_pkg::corner_t corner;
  tsbn_pkg::result_t res;
  logic              in_ready;
  logic              out_valid;

  assign corner.pos_x = in_ch.pos_x;
  assign corner.pos_y = in_ch.pos_y;
  assign corner.pos_z = in_ch.pos_z;
  assign corner.vel_x = in_ch.vel_x;
  assign corner.vel_y = in_ch.vel_y;
  assign corner.vel_z = in_ch.vel_z;
  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  tsbn_ctrl #(
    .MAX_TRIANGLES(MAX_TRIANGLES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tsbn_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_corner (corner),
    .cfg_we    (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .out_data  (res),
    .out_valid (out_valid),
    .out_ready (out_ch.ready)
  );

  assign out_ch.valid          = out_valid;
  assign out_ch.box_min_x      = res.box_min_x;
  assign out_ch.box_min_y      = res.box_min_y;
  assign out_ch.box_min_z      = res.box_min_z;
  assign out_ch.box_max_x      = res.box_max_x;
  assign out_ch.box_max_y      = res.box_max_y;
  assign out_ch.box_max_z      = res.box_max_z;
  assign out_ch.normal_x       = res.normal_x;
  assign out_ch.normal_y       = res.normal_y;
  assign out_ch.normal_z       = res.normal_z;
  assign out_ch.degenerate     = res.degenerate;
  assign out_ch.triangle_index = res.triangle_index;

endmodule

`default_nettype wire
